// ===== rtl/eps_pkg.sv =====
`default_nettype none

package eps_pkg;

    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam int unsigned RPM_UNIT        = 100;
    localparam int unsigned OIL_RELEASE_CAP = 250;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RPM_GUARD_ON       = 3'd0,
        CFG_RPM_LIMIT_HUNDREDS = 3'd1,
        CFG_RPM_HYST_HUNDREDS  = 3'd2,
        CFG_OIL_GUARD_ON       = 3'd3,
        CFG_OIL_TRIP_LEVEL     = 3'd4,
        CFG_OIL_HYST           = 3'd5,
        CFG_OIL_DELAY_TICKS    = 3'd6,
        CFG_CUT_KIND           = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] engine_rpm;
        logic [7:0]  oil_level;
    } sample_word_t;

    typedef struct packed {
        logic rpm_tripped;
        logic oil_tripped;
        logic fuel_cut;
        logic spark_cut;
    } result_word_t;

endpackage

`default_nettype wire

// ===== rtl/eps_chan_if.sv =====
`default_nettype none

interface eps_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/engine_protection_supervisor_unit.sv =====
`default_nettype none

// Over-speed and low oil pressure supervisor. Each sample word on the input channel is one
// protection tick and produces exactly one result word: the word is held in the input
// register, then passes through the latch logic into the output register.
// A new sample can be taken in every cycle; the rate is set by the single update of the
// latch and counter registers per word, and the block stalls only when the output register
// is full and not being drained. The configuration registers should be written only when
// no word is in flight.
module engine_protection_supervisor_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire eps_pkg::cfg_index_t           cfg_index,
    input  wire logic [eps_pkg::CFG_DATA_W-1:0] cfg_data,
    eps_chan_if.sink                           sample,
    eps_chan_if.source                         result
);
    import eps_pkg::*;

    logic       rpm_guard_on_reg;
    logic [7:0] rpm_limit_reg;
    logic [7:0] rpm_hyst_reg;
    logic       oil_guard_on_reg;
    logic [7:0] oil_trip_reg;
    logic [7:0] oil_hyst_reg;
    logic [7:0] oil_delay_reg;
    logic [1:0] cut_kind_reg;

    logic         in_valid_reg;
    sample_word_t in_data_reg;
    logic         out_valid_reg;
    result_word_t out_data_reg;
    result_word_t out_data_next;

    logic       rpm_latch_reg;
    logic       rpm_latch_next;
    logic       oil_latch_reg;
    logic       oil_latch_next;
    logic [7:0] oil_count_reg;
    logic [7:0] oil_count_next;

    logic advance;
    logic in_ready;

    logic        rpm_en;
    logic [15:0] rpm_limit_val;
    logic [15:0] rpm_release_val;
    logic [7:0]  rpm_diff;
    logic        oil_en;
    logic [8:0]  oil_sum;
    logic [7:0]  oil_release;
    logic [7:0]  oil_delay_eff;
    logic [7:0]  oil_count_inc;
    logic        any_trip;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign in_ready     = !in_valid_reg || advance;
    assign sample.ready = in_ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_guard_on_reg <= 1'b0;
            rpm_limit_reg    <= '0;
            rpm_hyst_reg     <= '0;
            oil_guard_on_reg <= 1'b0;
            oil_trip_reg     <= '0;
            oil_hyst_reg     <= '0;
            oil_delay_reg    <= '0;
            cut_kind_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RPM_GUARD_ON:       rpm_guard_on_reg <= cfg_data[0];
                CFG_RPM_LIMIT_HUNDREDS: rpm_limit_reg    <= cfg_data[7:0];
                CFG_RPM_HYST_HUNDREDS:  rpm_hyst_reg     <= cfg_data[7:0];
                CFG_OIL_GUARD_ON:       oil_guard_on_reg <= cfg_data[0];
                CFG_OIL_TRIP_LEVEL:     oil_trip_reg     <= cfg_data[7:0];
                CFG_OIL_HYST:           oil_hyst_reg     <= cfg_data[7:0];
                CFG_OIL_DELAY_TICKS:    oil_delay_reg    <= cfg_data[7:0];
                CFG_CUT_KIND:           cut_kind_reg     <= cfg_data[1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rpm_latch_reg <= 1'b0;
            oil_latch_reg <= 1'b0;
            oil_count_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                rpm_latch_reg <= rpm_latch_next;
                oil_latch_reg <= oil_latch_next;
                oil_count_reg <= oil_count_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && sample.valid)
        begin
            in_data_reg <= sample.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        rpm_en          = rpm_guard_on_reg && (rpm_limit_reg != '0);
        rpm_limit_val   = 16'(16'(rpm_limit_reg) * 16'(RPM_UNIT));
        rpm_diff        = rpm_limit_reg - rpm_hyst_reg;
        rpm_release_val = (rpm_limit_reg > rpm_hyst_reg)
                          ? 16'(16'(rpm_diff) * 16'(RPM_UNIT)) : '0;

        if (!rpm_en)
        begin
            rpm_latch_next = 1'b0;
        end
        else if (rpm_latch_reg)
        begin
            rpm_latch_next = !(in_data_reg.engine_rpm <= rpm_release_val);
        end
        else
        begin
            rpm_latch_next = (in_data_reg.engine_rpm >= rpm_limit_val);
        end

        oil_en        = oil_guard_on_reg && (oil_trip_reg != '0);
        oil_sum       = {1'b0, oil_trip_reg} + {1'b0, oil_hyst_reg};
        oil_release   = (oil_sum > 9'(OIL_RELEASE_CAP)) ? 8'(OIL_RELEASE_CAP) : oil_sum[7:0];
        oil_delay_eff = (oil_delay_reg == '0) ? 8'd1 : oil_delay_reg;
        oil_count_inc = (oil_count_reg == 8'hFF) ? oil_count_reg : oil_count_reg + 8'd1;

        oil_latch_next = oil_latch_reg;
        oil_count_next = oil_count_reg;
        if (!oil_en)
        begin
            oil_latch_next = 1'b0;
            oil_count_next = '0;
        end
        else if (oil_latch_reg)
        begin
            if (in_data_reg.oil_level > oil_release)
            begin
                oil_latch_next = 1'b0;
                oil_count_next = '0;
            end
        end
        else if (in_data_reg.oil_level <= oil_trip_reg)
        begin
            oil_count_next = oil_count_inc;
            oil_latch_next = (oil_count_inc >= oil_delay_eff);
        end
        else
        begin
            oil_count_next = '0;
        end

        any_trip                  = rpm_latch_next || oil_latch_next;
        out_data_next.rpm_tripped = rpm_latch_next;
        out_data_next.oil_tripped = oil_latch_next;
        out_data_next.fuel_cut    = any_trip && cut_kind_reg[0];
        out_data_next.spark_cut   = any_trip && cut_kind_reg[1];
    end

`ifndef SYNTH
    // The waiting result always reflects the current latch state.
    a_out_matches_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.rpm_tripped == rpm_latch_reg &&
                           out_data_reg.oil_tripped == oil_latch_reg))
        else $error("result word does not match latch state");

    // A held input word must not change while the output side is stalled.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("stalled input word was lost or changed");

    // The oil latch only sets when a word is processed.
    a_oil_set_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(oil_latch_reg) |-> $past(advance))
        else $error("oil latch set without a processed word");

    // A cut is only requested while some latch is set.
    a_cut_needs_trip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.fuel_cut || out_data_reg.spark_cut))
            |-> (rpm_latch_reg || oil_latch_reg))
        else $error("cut requested with no latch set");
`endif

endmodule

`default_nettype wire

// ===== test/tb_engine_protection_supervisor_unit.sv =====
`default_nettype none

module tb_engine_protection_supervisor_unit ();

    timeunit 1ns;
    timeprecision 1ps;

    import eps_pkg::*;

    class trip_tracker;
        bit           rpm_guard;
        logic [7:0]   rpm_limit;
        logic [7:0]   rpm_hyst;
        bit           oil_guard;
        logic [7:0]   oil_trip;
        logic [7:0]   oil_hyst;
        logic [7:0]   oil_delay;
        logic [1:0]   cut_kind;
        bit           rpm_latch;
        bit           oil_latch;
        logic [7:0]   low_count;
        result_word_t pending_flags[$];
        int unsigned  mismatches;

        function new();
            rpm_guard = 1'b0;
            rpm_limit = '0;
            rpm_hyst = '0;
            oil_guard = 1'b0;
            oil_trip = '0;
            oil_hyst = '0;
            oil_delay = '0;
            cut_kind = '0;
            rpm_latch = 1'b0;
            oil_latch = 1'b0;
            low_count = '0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [7:0] v);
            case (idx)
                CFG_RPM_GUARD_ON:       rpm_guard = v[0];
                CFG_RPM_LIMIT_HUNDREDS: rpm_limit = v;
                CFG_RPM_HYST_HUNDREDS:  rpm_hyst = v;
                CFG_OIL_GUARD_ON:       oil_guard = v[0];
                CFG_OIL_TRIP_LEVEL:     oil_trip = v;
                CFG_OIL_HYST:           oil_hyst = v;
                CFG_OIL_DELAY_TICKS:    oil_delay = v;
                CFG_CUT_KIND:           cut_kind = v[1:0];
                default:                ;
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void note_sample(sample_word_t s);
            logic [15:0]  trip_rpm;
            logic [15:0]  hyst_rpm;
            logic [15:0]  release_rpm;
            logic [8:0]   release_oil;
            logic [7:0]   need;
            result_word_t r;
            if (rpm_guard && rpm_limit != 8'd0)
            begin
                trip_rpm = 16'(rpm_limit) * 16'(RPM_UNIT);
                hyst_rpm = 16'(rpm_hyst) * 16'(RPM_UNIT);
                release_rpm = (trip_rpm > hyst_rpm) ? trip_rpm - hyst_rpm : 16'd0;
                if (rpm_latch)
                begin
                    if (s.engine_rpm <= release_rpm)
                        rpm_latch = 1'b0;
                end
                else if (s.engine_rpm >= trip_rpm)
                    rpm_latch = 1'b1;
            end
            else
                rpm_latch = 1'b0;

            if (oil_guard && oil_trip != 8'd0)
            begin
                release_oil = 9'(oil_trip) + 9'(oil_hyst);
                if (release_oil > 9'(OIL_RELEASE_CAP))
                    release_oil = 9'(OIL_RELEASE_CAP);
                need = (oil_delay == 8'd0) ? 8'd1 : oil_delay;
                if (oil_latch)
                begin
                    if (9'(s.oil_level) > release_oil)
                    begin
                        oil_latch = 1'b0;
                        low_count = '0;
                    end
                end
                else if (s.oil_level <= oil_trip)
                begin
                    if (low_count != 8'hFF)
                        low_count = low_count + 8'd1;
                    if (low_count >= need)
                        oil_latch = 1'b1;
                end
                else
                    low_count = '0;
            end
            else
            begin
                oil_latch = 1'b0;
                low_count = '0;
            end

            r.rpm_tripped = rpm_latch;
            r.oil_tripped = oil_latch;
            r.fuel_cut = (rpm_latch || oil_latch) && cut_kind[0];
            r.spark_cut = (rpm_latch || oil_latch) && cut_kind[1];
            pending_flags.push_back(r);
        endfunction

        task compare_flag(string name, logic got, logic want);
            if (got !== want)
                report_mismatch($sformatf("%s got %b expected %b", name, got, want));
        endtask

        task check_flags(result_word_t got);
            result_word_t want;
            if (pending_flags.size() == 0)
            begin
                report_mismatch($sformatf("result word %b with nothing expected", got));
                return;
            end
            want = pending_flags.pop_front();
            compare_flag("rpm_tripped", got.rpm_tripped, want.rpm_tripped);
            compare_flag("oil_tripped", got.oil_tripped, want.oil_tripped);
            compare_flag("fuel_cut", got.fuel_cut, want.fuel_cut);
            compare_flag("spark_cut", got.spark_cut, want.spark_cut);
        endtask
    endclass

    typedef enum {OIL_LOW, OIL_BAND, OIL_HIGH, OIL_ANY} oil_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    eps_chan_if #(.payload_t(sample_word_t)) sample_if ();
    eps_chan_if #(.payload_t(result_word_t)) result_if ();

    trip_tracker sb;
    bit          tx_busy;
    bit          tx_idle;
    bit          rx_stalls;
    oil_mode_t   oil_mode;
    int unsigned oil_run;

    engine_protection_supervisor_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_if),
        .result    (result_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            sb.check_flags(result_if.data);
    end

    initial
    begin
        int unsigned hold;
        int unsigned pick;
        bit          level;
        hold = 0;
        level = 1'b0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rx_stalls)
                level = 1'b1;
            else if (hold == 0)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 60)
                begin
                    level = 1'b1;
                    hold = $urandom_range(14, 0);
                end
                else if (pick < 90)
                begin
                    level = 1'b0;
                    hold = $urandom_range(2, 0);
                end
                else
                begin
                    level = 1'b0;
                    hold = $urandom_range(39, 7);
                end
            end
            else
                hold--;
            result_if.ready <= level;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned pick;
        if (!tx_idle)
            return 0;
        pick = $urandom_range(99, 0);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(3, 1);
        if (pick < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [15:0] pick_rpm();
        int trip;
        int rel;
        int v;
        trip = int'(sb.rpm_limit) * int'(RPM_UNIT);
        rel = trip - int'(sb.rpm_hyst) * int'(RPM_UNIT);
        if (rel < 0)
            rel = 0;
        case ($urandom_range(9, 0))
            0, 1, 2: v = trip - 150 + int'($urandom_range(300, 0));
            3, 4:    v = rel - 150 + int'($urandom_range(300, 0));
            5:       v = trip + int'($urandom_range(2000, 0));
            6:       v = int'($urandom_range(rel, 0));
            7:
            begin
                case ($urandom_range(5, 0))
                    0:       v = 0;
                    1:       v = 65535;
                    2:       v = trip;
                    3:       v = trip - 1;
                    4:       v = rel;
                    default: v = rel + 1;
                endcase
            end
            default: v = int'($urandom_range(65535, 0));
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    function automatic logic [7:0] pick_oil();
        int unsigned trip;
        int unsigned rel;
        int unsigned pick;
        trip = sb.oil_trip;
        rel = trip + sb.oil_hyst;
        if (rel > OIL_RELEASE_CAP)
            rel = OIL_RELEASE_CAP;
        if (oil_run == 0)
        begin
            pick = $urandom_range(9, 0);
            if (pick < 4)
                oil_mode = OIL_LOW;
            else if (pick < 6)
                oil_mode = OIL_BAND;
            else if (pick < 8)
                oil_mode = OIL_HIGH;
            else
                oil_mode = OIL_ANY;
            if ($urandom_range(19, 0) == 0)
                oil_run = $urandom_range(300, 20);
            else
                oil_run = $urandom_range(sb.oil_delay + 3, 1);
        end
        oil_run--;
        case (oil_mode)
            OIL_BAND:
            begin
                if (rel > trip)
                    return 8'($urandom_range(rel, trip + 1));
                return 8'($urandom_range(trip, 0));
            end
            OIL_HIGH:
            begin
                if (rel >= 255)
                    return 8'd255;
                return 8'($urandom_range(255, rel + 1));
            end
            OIL_LOW: return 8'($urandom_range(trip, 0));
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic send_sample(input logic [15:0] rpm, input logic [7:0] oil);
        int unsigned  gap;
        sample_word_t w;
        gap = pick_gap();
        w.engine_rpm = rpm;
        w.oil_level = oil;
        if (gap != 0)
        begin
            if (tx_busy)
            begin
                sample_if.valid <= 1'b0;
                tx_busy = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.data <= w;
        tx_busy = 1'b1;
        do
            @(posedge clk);
        while (!sample_if.ready);
        sb.note_sample(w);
    endtask

    task automatic drain();
        if (tx_busy)
        begin
            sample_if.valid <= 1'b0;
            tx_busy = 1'b0;
        end
        while (sb.pending_flags.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input cfg_index_t idx, input logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    task automatic apply_settings(input bit g_rpm, input logic [7:0] lim,
                                  input logic [7:0] rhyst, input bit g_oil,
                                  input logic [7:0] trip, input logic [7:0] ohyst,
                                  input logic [7:0] delay, input logic [1:0] cut);
        drain();
        repeat (4) @(posedge clk);
        set_reg(CFG_RPM_GUARD_ON, {7'd0, g_rpm});
        set_reg(CFG_RPM_LIMIT_HUNDREDS, lim);
        set_reg(CFG_RPM_HYST_HUNDREDS, rhyst);
        set_reg(CFG_OIL_GUARD_ON, {7'd0, g_oil});
        set_reg(CFG_OIL_TRIP_LEVEL, trip);
        set_reg(CFG_OIL_HYST, ohyst);
        set_reg(CFG_OIL_DELAY_TICKS, delay);
        set_reg(CFG_CUT_KIND, {6'd0, cut});
        cfg_we <= 1'b0;
        oil_run = 0;
    endtask

    function automatic logic [7:0] pick_cfg_byte();
        case ($urandom_range(9, 0))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return 8'($urandom_range(254, 2));
        endcase
    endfunction

    function automatic logic [7:0] pick_delay();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return 8'($urandom_range(4, 0));
            4, 5:       return 8'd0;
            6:          return 8'($urandom_range(255, 0));
            default:    return 8'($urandom_range(12, 0));
        endcase
    endfunction

    initial
    begin
        sb = new();
        tx_busy = 1'b0;
        tx_idle = 1'b1;
        rx_stalls = 1'b1;
        oil_mode = OIL_ANY;
        oil_run = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_RPM_GUARD_ON;
        cfg_data <= '0;
        sample_if.valid <= 1'b0;
        sample_if.data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset both channels are off, so nothing may trip.
        send_sample(16'd0, 8'd0);
        send_sample(16'hFFFF, 8'hFF);
        send_sample(16'hAAAA, 8'h55);

        apply_settings(1'b1, 8'd30, 8'd5, 1'b1, 8'd40, 8'd20, 8'd3, 2'd3);
        send_sample(16'd2999, 8'd41);
        send_sample(16'd3000, 8'd40);
        send_sample(16'd2600, 8'd40);
        send_sample(16'd2501, 8'd40);
        send_sample(16'd2500, 8'd60);
        send_sample(16'd2999, 8'd61);
        send_sample(16'd0, 8'd0);

        // Hysteresis equal to the limit, release level capped below the trip level.
        apply_settings(1'b1, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0, 2'd1);
        send_sample(16'd25499, 8'd0);
        send_sample(16'd25500, 8'd255);
        send_sample(16'd1, 8'd250);
        send_sample(16'd0, 8'd251);
        send_sample(16'd65535, 8'd255);

        // Disabling a channel while latched clears it.
        apply_settings(1'b1, 8'd0, 8'd9, 1'b0, 8'd10, 8'd3, 8'd2, 2'd2);
        send_sample(16'd65535, 8'd0);
        send_sample(16'd0, 8'd5);

        apply_settings(1'b1, 8'd1, 8'd0, 1'b1, 8'd1, 8'd0, 8'd1, 2'd2);
        send_sample(16'd100, 8'd1);
        send_sample(16'd101, 8'd1);
        send_sample(16'd100, 8'd2);

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 3)
                apply_settings(1'b1, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255, 2'd3);
            else if (ph == 7)
                apply_settings(1'b1, 8'd1, 8'd0, 1'b1, 8'd1, 8'd0, 8'd1,
                               2'($urandom_range(3, 0)));
            else
                apply_settings($urandom_range(9, 0) != 0, pick_cfg_byte(), pick_cfg_byte(),
                               $urandom_range(9, 0) != 0, pick_cfg_byte(), pick_cfg_byte(),
                               pick_delay(), 2'($urandom_range(3, 0)));
            tx_idle = (ph % 4 != 1);
            rx_stalls = (ph % 3 != 1);
            for (int n = 0; n < 121; n++)
            begin
                if (n == 60 && (ph == 0 || $urandom_range(1, 0) == 1))
                    drain();
                send_sample(pick_rpm(), pick_oil());
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.pending_flags.size() != 0)
            sb.report_mismatch("expected result words never arrived");
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/eps_pkg.sv
rtl/eps_chan_if.sv
rtl/engine_protection_supervisor_unit.sv
test/tb_engine_protection_supervisor_unit.sv
